// File: hdl/byte_stack_multiwidth_defines.svh
// assertion macros for the byte stack checker
// depends on nothing; taken in by the checker file only
`ifndef BYTE_STACK_MULTIWIDTH_DEFINES_SVH
`define BYTE_STACK_MULTIWIDTH_DEFINES_SVH

// consequent checked in the same cycle
`define BST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("byte stack check failed");

// consequent checked in the next cycle
`define BST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("byte stack check failed");

`endif

// File: hdl/bst_pkg.sv
// shared types, codes and helpers for the byte stack
// no dependencies
package bst_pkg;

    localparam int OP_W       = 3;
    localparam int WC_W       = 2;
    localparam int VAL_W      = 64;
    localparam int CNT_W      = 13;
    localparam int DU_W       = 13;
    localparam int ST_W       = 2;
    localparam int BYTE_W     = 8;
    localparam int LANES      = 8;
    localparam int LANE_SEL_W = 3;
    localparam int NB_W       = 4;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH     = 3'd0,
        OP_POP      = 3'd1,
        OP_PEEK     = 3'd2,
        OP_READ_IDX = 3'd3,
        OP_READ_TOP = 3'd4,
        OP_DROP     = 3'd5,
        OP_RESERVE  = 3'd6
    } bst_op_t;

    typedef enum logic [WC_W-1:0] {
        WC_BYTE  = 2'd0,
        WC_WORD  = 2'd1,
        WC_DWORD = 2'd2
    } bst_width_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2
    } bst_status_t;

    // what the read stage needs to finish an item
    typedef struct packed {
        logic [LANE_SEL_W-1:0] shift;
        logic [NB_W-1:0]       nbytes;
        logic [DU_W-1:0]       depth_used;
        logic                  is_empty;
        bst_status_t           status;
    } bst_info_t;

    // bytes moved by an access width code, zero when the code is unused
    function automatic logic [NB_W-1:0] width_bytes(input logic [WC_W-1:0] code);
        logic [NB_W-1:0] n;
        case (code)
            WC_BYTE:  n = NB_W'(1);
            WC_WORD:  n = NB_W'(4);
            WC_DWORD: n = NB_W'(8);
            default:  n = '0;
        endcase
        return n;
    endfunction

endpackage

// File: hdl/bst_if.sv
// command and response channel interfaces for the byte stack
// depends on bst_pkg
interface bst_cmd_if;
    import bst_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [WC_W-1:0]  width_code;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] count;

    modport source (output valid, output operation, output width_code, output value,
                    output count, input ready);
    modport sink   (input valid, input operation, input width_code, input value,
                    input count, output ready);
endinterface

interface bst_rsp_if;
    import bst_pkg::*;

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] read_data;
    logic [DU_W-1:0]  depth_used;
    logic             is_empty;
    logic [ST_W-1:0]  status;

    modport source (output valid, output read_data, output depth_used, output is_empty,
                    output status, input ready);
    modport sink   (input valid, input read_data, input depth_used, input is_empty,
                    input status, output ready);
endinterface

// File: hdl/bst_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module bst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/bst_ctrl.sv
// command decode, top pointer, clearing sweep and per-lane ram addressing
// depends on bst_pkg and bst_cmd_if
module bst_ctrl #(
    parameter int DEPTH = 4096,
    localparam int ADDR_W = $clog2(DEPTH),
    localparam int ROW_W = ADDR_W - bst_pkg::LANE_SEL_W
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    bst_cmd_if.sink                                         cmd,
    input  logic                                            can_accept,
    output logic                                            accept,
    output bst_pkg::bst_info_t                              info,
    output logic                                            mem_re,
    output logic [bst_pkg::LANES-1:0]                       lane_we,
    output logic [bst_pkg::LANES-1:0][ROW_W-1:0]            lane_row,
    output logic [bst_pkg::LANES-1:0][bst_pkg::BYTE_W-1:0]  lane_wdata
);
    import bst_pkg::*;

    localparam int PTR_W = $clog2(DEPTH + 1);
    localparam int ROWS  = (DEPTH + LANES - 1) / LANES;
    localparam int SUM_W = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
    localparam logic [ROW_W:0]   ROWS_V   = (ROW_W + 1)'(ROWS);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [SUM_W-1:0] LIMIT    = SUM_W'(DEPTH);

    typedef enum logic [1:0] {
        PH_CLEAR = 2'b01,
        PH_RUN   = 2'b10
    } bst_phase_t;

    bst_phase_t       phase_reg, phase_next;
    logic [ROW_W-1:0] clr_row_reg, clr_row_next;
    logic [PTR_W-1:0] top_reg, top_next;

    logic [NB_W-1:0]  wbytes;
    logic [SUM_W-1:0] top_x, cnt_x, w_x, base_x, top_new;
    logic [NB_W-1:0]  rd_n;
    logic             wr_ok;
    bst_status_t      status;
    logic [LANE_SEL_W-1:0] shift;
    logic [ROW_W-1:0] row, row_nx;
    logic [ROW_W:0]   row_up;

    assign cmd.ready = can_accept && (phase_reg == PH_RUN);
    assign accept    = cmd.valid && cmd.ready;
    assign mem_re    = accept;

    // operation decode
    always_comb
    begin
        wbytes  = width_bytes(cmd.width_code);
        top_x   = SUM_W'(top_reg);
        cnt_x   = SUM_W'(cmd.count);
        w_x     = SUM_W'(wbytes);
        status  = ST_OK;
        top_new = top_x;
        base_x  = top_x;
        rd_n    = '0;
        wr_ok   = 1'b0;
        unique case (bst_op_t'(cmd.operation)) inside
            OP_PUSH:
            begin
                if (wbytes == '0)
                begin
                    status = ST_UNDER;
                end
                else if ((top_x + w_x) > LIMIT)
                begin
                    status = ST_OVER;
                end
                else
                begin
                    wr_ok   = 1'b1;
                    top_new = top_x + w_x;
                end
            end
            OP_POP, OP_PEEK:
            begin
                if ((wbytes == '0) || (top_x < w_x))
                begin
                    status = ST_UNDER;
                end
                else
                begin
                    base_x = top_x - w_x;
                    rd_n   = wbytes;
                    if (cmd.operation == OP_POP)
                    begin
                        top_new = top_x - w_x;
                    end
                end
            end
            OP_READ_IDX:
            begin
                if (cnt_x >= top_x)
                begin
                    status = ST_UNDER;
                end
                else
                begin
                    base_x = cnt_x;
                    rd_n   = NB_W'(1);
                end
            end
            OP_READ_TOP:
            begin
                if (cnt_x >= top_x)
                begin
                    status = ST_UNDER;
                end
                else
                begin
                    base_x = top_x - cnt_x - SUM_W'(1);
                    rd_n   = NB_W'(1);
                end
            end
            OP_DROP:
            begin
                if (cnt_x > top_x)
                begin
                    status = ST_UNDER;
                end
                else
                begin
                    top_new = top_x - cnt_x;
                end
            end
            OP_RESERVE:
            begin
                if ((top_x + cnt_x) > LIMIT)
                begin
                    status = ST_OVER;
                end
                else
                begin
                    top_new = top_x + cnt_x;
                end
            end
            default:
            begin
                status = ST_UNDER;
            end
        endcase
    end

    // byte address split over the eight lanes
    always_comb
    begin
        logic [LANE_SEL_W-1:0] off;
        shift  = base_x[LANE_SEL_W-1:0];
        row    = base_x[ADDR_W-1:LANE_SEL_W];
        row_up = {1'b0, row} + (ROW_W + 1)'(1);
        row_nx = (row_up < ROWS_V) ? row_up[ROW_W-1:0] : row;
        for (int l = 0; l < LANES; l++)
        begin
            off = LANE_SEL_W'(l) - shift;
            if (phase_reg == PH_CLEAR)
            begin
                lane_row[l]   = clr_row_reg;
                lane_wdata[l] = '0;
                lane_we[l]    = 1'b1;
            end
            else
            begin
                lane_row[l]   = (LANE_SEL_W'(l) < shift) ? row_nx : row;
                lane_wdata[l] = cmd.value[{off, 3'b000} +: BYTE_W];
                lane_we[l]    = accept && wr_ok && ({1'b0, off} < wbytes);
            end
        end
    end

    always_comb
    begin
        info.shift      = shift;
        info.nbytes     = rd_n;
        info.depth_used = DU_W'(PTR_W'(top_new));
        info.is_empty   = (PTR_W'(top_new) == '0);
        info.status     = status;
    end

    always_comb
    begin
        phase_next   = phase_reg;
        clr_row_next = clr_row_reg;
        top_next     = top_reg;
        unique case (phase_reg)
            PH_CLEAR:
            begin
                clr_row_next = clr_row_reg + ROW_W'(1);
                if (clr_row_reg == ROW_LAST)
                begin
                    phase_next = PH_RUN;
                end
            end
            PH_RUN:
            begin
                if (accept)
                begin
                    top_next = PTR_W'(top_new);
                end
            end
            default:
            begin
                phase_next = PH_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_CLEAR;
            clr_row_reg <= '0;
            top_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            clr_row_reg <= clr_row_next;
            top_reg     <= top_next;
        end
    end

endmodule

// File: hdl/bst_align.sv
// read stage and output register: lane data gathered into the result item
// depends on bst_pkg and bst_rsp_if
module bst_align (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            accept,
    input  bst_pkg::bst_info_t                              info,
    input  logic [bst_pkg::LANES-1:0][bst_pkg::BYTE_W-1:0]  lane_data,
    output logic                                            can_accept,
    bst_rsp_if.source                                       rsp
);
    import bst_pkg::*;

    logic             s1_valid_reg, s1_valid_next;
    bst_info_t        s1_info_reg;
    logic             out_valid_reg, out_valid_next;
    logic [VAL_W-1:0] read_data_reg, read_data_next;
    logic [DU_W-1:0]  depth_used_reg;
    logic             is_empty_reg;
    bst_status_t      status_reg;
    logic             out_free, s1_move;

    assign out_free   = !out_valid_reg || rsp.ready;
    assign s1_move    = s1_valid_reg && out_free;
    assign can_accept = !s1_valid_reg || out_free;

    // little-endian gather, rotated by the base lane
    always_comb
    begin
        logic [LANE_SEL_W-1:0] sel;
        read_data_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            sel = s1_info_reg.shift + LANE_SEL_W'(i);
            if (NB_W'(i) < s1_info_reg.nbytes)
            begin
                read_data_next[BYTE_W*i +: BYTE_W] = lane_data[sel];
            end
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_info_reg <= info;
        end
        if (s1_move)
        begin
            read_data_reg  <= read_data_next;
            depth_used_reg <= s1_info_reg.depth_used;
            is_empty_reg   <= s1_info_reg.is_empty;
            status_reg     <= s1_info_reg.status;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = read_data_reg;
    assign rsp.depth_used = depth_used_reg;
    assign rsp.is_empty   = is_empty_reg;
    assign rsp.status     = status_reg;

endmodule

// File: hdl/byte_stack_multiwidth.sv
// byte stack top level: decode, eight byte-lane rams and the result stage
// depends on bst_pkg, bst_if, bst_ram, bst_ctrl and bst_align
//
// usage
//   cmd carries one item per operation (push, pop, peek, read at index,
//   read from top, drop, reserve); rsp returns exactly one item for each,
//   in order, with the read value, the byte count left and a status code
//   each taken item is registered in the read stage, then in the output
//   register; throughput: one item per cycle while rsp moves; items make
//   a single read and at most one write in each of the eight byte-lane
//   rams, so a doubleword at any byte alignment fits in one ram access
//   reset: the top pointer goes to zero and the rams are swept to zero,
//   one row of eight bytes a cycle over DEPTH/8 rows (512 at the default);
//   cmd.ready stays low during the sweep
//   receiver stall: the output register holds its item, one more item is
//   taken into the read stage and then cmd.ready drops until rsp moves
module byte_stack_multiwidth #(
    parameter int DEPTH = 4096
) (
    input  logic       clk,
    input  logic       rst_n,
    bst_cmd_if.sink    cmd,
    bst_rsp_if.source  rsp
);
    import bst_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROW_W  = ADDR_W - LANE_SEL_W;
    localparam int ROWS   = (DEPTH + LANES - 1) / LANES;

    logic                            accept;
    logic                            can_accept;
    bst_info_t                       info;
    logic                            mem_re;
    logic [LANES-1:0]                lane_we;
    logic [LANES-1:0][ROW_W-1:0]     lane_row;
    logic [LANES-1:0][BYTE_W-1:0]    lane_wdata;
    logic [LANES-1:0][BYTE_W-1:0]    lane_rdata;

    bst_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .can_accept (can_accept),
        .accept     (accept),
        .info       (info),
        .mem_re     (mem_re),
        .lane_we    (lane_we),
        .lane_row   (lane_row),
        .lane_wdata (lane_wdata)
    );

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        bst_ram #(
            .WIDTH (BYTE_W),
            .DEPTH (ROWS)
        ) u_ram (
            .clk   (clk),
            .we    (lane_we[l]),
            .waddr (lane_row[l]),
            .wdata (lane_wdata[l]),
            .re    (mem_re),
            .raddr (lane_row[l]),
            .rdata (lane_rdata[l])
        );
    end

    bst_align u_align (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .info       (info),
        .lane_data  (lane_rdata),
        .can_accept (can_accept),
        .rsp        (rsp)
    );

endmodule

// File: hdl/bst_checker.sv
// port-level checks for the byte stack, bound to the top level
// depends on bst_pkg and byte_stack_multiwidth_defines.svh
`include "byte_stack_multiwidth_defines.svh"

module bst_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       cmd_valid,
    input logic                       cmd_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic [bst_pkg::VAL_W-1:0]  read_data,
    input logic [bst_pkg::DU_W-1:0]   depth_used,
    input logic                       is_empty,
    input logic [bst_pkg::ST_W-1:0]   status
);
    import bst_pkg::*;

    logic cmd_fire;
    logic rsp_stall;

    assign cmd_fire  = cmd_valid && cmd_ready;
    assign rsp_stall = rsp_valid && !rsp_ready;

    // rsp_valid is high when a taken item could first reach the output register
    `BST_ASSERT_NOW(a_result_follows, clk, rst_n, cmd_fire, ##2 rsp_valid)

    // an ignored operation returns no data
    `BST_ASSERT_NOW(a_fail_no_data, clk, rst_n, rsp_valid && (status != ST_OK), read_data == '0)

    `BST_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_stall, rsp_valid)

    `BST_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_stall, $stable(read_data) && $stable(depth_used) && $stable(is_empty) && $stable(status))

endmodule

bind byte_stack_multiwidth bst_checker u_bst_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .read_data  (rsp.read_data),
    .depth_used (rsp.depth_used),
    .is_empty   (rsp.is_empty),
    .status     (rsp.status)
);

// File: tb/bst_result_checker.sv
// result checker for the byte stack: keeps its own byte store and top count,
// works out one result per command item and compares it with each response item
// depends on bst_pkg and the bst_cmd_if / bst_rsp_if interfaces
module bst_result_checker #(
    parameter int DEPTH = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    bst_cmd_if          cmd,
    bst_rsp_if          rsp,
    output int unsigned err_count,
    output int unsigned pending
);
    import bst_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0] read_data;
        logic [DU_W-1:0]  depth_used;
        logic             is_empty;
        bst_status_t      status;
    } stack_result_t;

    logic [BYTE_W-1:0] shadow_bytes [DEPTH];
    int unsigned       bytes_held;
    stack_result_t     expected_q [$];

    function automatic int unsigned access_bytes(input logic [WC_W-1:0] code);
        int unsigned n;
        case (code)
            WC_BYTE:  n = 1;
            WC_WORD:  n = 4;
            WC_DWORD: n = 8;
            default:  n = 0;
        endcase
        return n;
    endfunction

    function automatic stack_result_t apply_stack_op(input logic [OP_W-1:0]  op,
                                                     input logic [WC_W-1:0]  wc,
                                                     input logic [VAL_W-1:0] val,
                                                     input logic [CNT_W-1:0] cnt);
        stack_result_t r;
        int unsigned   nb;
        r        = '0;
        r.status = ST_OK;
        nb       = access_bytes(wc);
        case (op)
            OP_PUSH:
            begin
                if (nb == 0)
                    r.status = ST_UNDER;
                else if (bytes_held + nb > DEPTH)
                    r.status = ST_OVER;
                else
                begin
                    for (int i = 0; i < nb; i++)
                        shadow_bytes[bytes_held + i] = val[8*i +: 8];
                    bytes_held += nb;
                end
            end
            OP_POP, OP_PEEK:
            begin
                if (nb == 0 || bytes_held < nb)
                    r.status = ST_UNDER;
                else
                begin
                    for (int i = 0; i < nb; i++)
                        r.read_data[8*i +: 8] = shadow_bytes[bytes_held - nb + i];
                    if (op == OP_POP)
                        bytes_held -= nb;
                end
            end
            OP_READ_IDX:
            begin
                if (cnt >= bytes_held)
                    r.status = ST_UNDER;
                else
                    r.read_data[7:0] = shadow_bytes[cnt];
            end
            OP_READ_TOP:
            begin
                if (cnt >= bytes_held)
                    r.status = ST_UNDER;
                else
                    r.read_data[7:0] = shadow_bytes[bytes_held - cnt - 1];
            end
            OP_DROP:
            begin
                if (cnt > bytes_held)
                    r.status = ST_UNDER;
                else
                    bytes_held -= cnt;
            end
            OP_RESERVE:
            begin
                if (bytes_held + cnt > DEPTH)
                    r.status = ST_OVER;
                else
                    bytes_held += cnt;
            end
            default:
                r.status = ST_UNDER;
        endcase
        r.depth_used = DU_W'(bytes_held);
        r.is_empty   = (bytes_held == 0);
        return r;
    endfunction

    task automatic check_response(input stack_result_t got);
        stack_result_t want;
        if (expected_q.size() == 0)
        begin
            if (err_count < 10)
                $display("unexpected response item: data %h depth %0d empty %b status %0d",
                         got.read_data, got.depth_used, got.is_empty, got.status);
            err_count++;
        end
        else
        begin
            want = expected_q.pop_front();
            if (got.read_data !== want.read_data || got.depth_used !== want.depth_used ||
                got.is_empty !== want.is_empty || got.status !== want.status)
            begin
                if (err_count < 10)
                    $display("mismatch: data %h/%h depth %0d/%0d empty %b/%b status %0d/%0d",
                             want.read_data, got.read_data, want.depth_used, got.depth_used,
                             want.is_empty, got.is_empty, want.status, got.status);
                err_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < DEPTH; a++)
                shadow_bytes[a] = '0;
            bytes_held = 0;
            expected_q.delete();
            err_count = 0;
            pending   = 0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
                expected_q.push_back(apply_stack_op(cmd.operation, cmd.width_code,
                                                    cmd.value, cmd.count));
            if (rsp.valid && rsp.ready)
                check_response({rsp.read_data, rsp.depth_used, rsp.is_empty,
                                bst_status_t'(rsp.status)});
            pending = expected_q.size();
        end
    end

endmodule

// File: tb/byte_stack_multiwidth_tb.sv
// top of the byte stack testbench: clock, reset, command items and response stalls
// depends on bst_pkg, the bst interfaces, byte_stack_multiwidth and bst_result_checker
module byte_stack_multiwidth_tb;
    import bst_pkg::*;

    localparam int              STACK_BYTES = 4096;
    localparam logic [OP_W-1:0] OP_UNUSED   = 3'd7;
    localparam logic [WC_W-1:0] WC_UNUSED   = 2'd3;

    logic        clk;
    logic        rst_n;
    int unsigned err_count;
    int unsigned pending;
    int unsigned fill_est;
    int          burst_left;

    bst_cmd_if cmd ();
    bst_rsp_if rsp ();

    byte_stack_multiwidth #(
        .DEPTH (STACK_BYTES)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    bst_result_checker #(
        .DEPTH (STACK_BYTES)
    ) i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp       (rsp),
        .err_count (err_count),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("byte_stack_multiwidth_tb: done, errors");
        $finish;
    end

    // receiver: ready rate changes from one stretch to the next
    initial
    begin
        int seg_left;
        int ready_pct;
        rsp.ready <= 1'b0;
        seg_left  = 0;
        ready_pct = 100;
        forever
        begin
            @(posedge clk);
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(16, 160);
                case ($urandom_range(0, 3))
                    0:       ready_pct = 100;
                    1:       ready_pct = 75;
                    2:       ready_pct = 50;
                    default: ready_pct = 15;
                endcase
            end
            seg_left--;
            rsp.ready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    function automatic int unsigned width_to_bytes(input logic [WC_W-1:0] wc);
        int unsigned n;
        case (wc)
            WC_BYTE:  n = 1;
            WC_WORD:  n = 4;
            WC_DWORD: n = 8;
            default:  n = 0;
        endcase
        return n;
    endfunction

    task automatic issue_op(input logic [OP_W-1:0]  op,
                            input logic [WC_W-1:0]  wc,
                            input logic [VAL_W-1:0] val,
                            input logic [CNT_W-1:0] cnt);
        int          gap;
        int unsigned nb;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(1, 9);
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        cmd.valid      <= 1'b1;
        cmd.operation  <= op;
        cmd.width_code <= wc;
        cmd.value      <= val;
        cmd.count      <= cnt;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        // running fill level, used only to pick ops and aim counts near the top
        nb = width_to_bytes(wc);
        case (op)
            OP_PUSH:    if (nb != 0 && fill_est + nb <= STACK_BYTES) fill_est += nb;
            OP_POP:     if (nb != 0 && fill_est >= nb) fill_est -= nb;
            OP_DROP:    if (cnt <= fill_est) fill_est -= cnt;
            OP_RESERVE: if (fill_est + cnt <= STACK_BYTES) fill_est += cnt;
            default:    ;
        endcase
    endtask

    initial
    begin
        logic [OP_W-1:0]  op;
        logic [WC_W-1:0]  wc;
        logic [VAL_W-1:0] val;
        logic [CNT_W-1:0] cnt;
        int unsigned      sel;
        int unsigned      pick;
        rst_n          <= 1'b0;
        cmd.valid      <= 1'b0;
        cmd.operation  <= OP_PUSH;
        cmd.width_code <= WC_BYTE;
        cmd.value      <= '0;
        cmd.count      <= '0;
        fill_est   = 0;
        burst_left = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // empty stack
        issue_op(OP_POP,      WC_BYTE,  '0, '0);
        issue_op(OP_PEEK,     WC_DWORD, '0, '0);
        issue_op(OP_READ_IDX, WC_BYTE,  '0, '0);
        issue_op(OP_READ_TOP, WC_BYTE,  '0, '0);
        issue_op(OP_DROP,     WC_BYTE,  '0, '0);
        issue_op(OP_DROP,     WC_BYTE,  '0, 13'd1);
        // each width, then an unused width code, then peeks, reads, pops and an unused op
        issue_op(OP_PUSH,     WC_BYTE,  64'hA5, '0);
        issue_op(OP_PUSH,     WC_WORD,  '1, '1);
        issue_op(OP_PUSH,     WC_DWORD, 64'h0123_4567_89AB_CDEF, '0);
        issue_op(OP_PUSH,     WC_UNUSED, '1, '0);
        issue_op(OP_PEEK,     WC_BYTE,  '0, '0);
        issue_op(OP_PEEK,     WC_WORD,  '0, '0);
        issue_op(OP_PEEK,     WC_UNUSED, '0, '0);
        issue_op(OP_READ_IDX, WC_UNUSED, '0, 13'd12);
        issue_op(OP_READ_IDX, WC_BYTE,  '0, 13'd13);
        issue_op(OP_READ_TOP, WC_DWORD, '0, 13'd12);
        issue_op(OP_READ_TOP, WC_BYTE,  '0, '1);
        issue_op(OP_POP,      WC_DWORD, '0, '0);
        issue_op(OP_POP,      WC_UNUSED, '0, '0);
        issue_op(OP_POP,      WC_WORD,  '0, '0);
        issue_op(OP_UNUSED,   WC_BYTE,  '0, '0);
        // fill to the last byte, overflow by push and by reserve, read the last byte, drop all
        issue_op(OP_RESERVE,  WC_BYTE,  '0, 13'(STACK_BYTES - 1));
        issue_op(OP_PUSH,     WC_WORD,  64'hDEAD_BEEF, '0);
        issue_op(OP_RESERVE,  WC_BYTE,  '0, 13'd1);
        issue_op(OP_READ_IDX, WC_BYTE,  '0, 13'(STACK_BYTES - 1));
        issue_op(OP_DROP,     WC_BYTE,  '0, 13'(STACK_BYTES));

        for (int n = 0; n < 1250; n++)
        begin
            sel  = $urandom_range(0, 99);
            pick = $urandom_range(0, 9);
            val  = {$urandom, $urandom};
            cnt  = '0;
            case ($urandom_range(0, 2))
                0:       wc = WC_BYTE;
                1:       wc = WC_WORD;
                default: wc = WC_DWORD;
            endcase
            if ($urandom_range(0, 39) == 0)
                wc = WC_UNUSED;
            if (sel < 32)      op = OP_PUSH;
            else if (sel < 52) op = OP_POP;
            else if (sel < 62) op = OP_PEEK;
            else if (sel < 72) op = OP_READ_IDX;
            else if (sel < 81) op = OP_READ_TOP;
            else if (sel < 89) op = OP_DROP;
            else if (sel < 97) op = OP_RESERVE;
            else               op = OP_UNUSED;
            if (op == OP_PUSH && fill_est > 3600 && pick < 8)
            begin
                op   = OP_DROP;
                pick = 9;
            end
            case (op)
                OP_READ_IDX, OP_READ_TOP:
                begin
                    if (pick == 0)
                        cnt = CNT_W'($urandom_range(0, 8191));
                    else if (pick == 1)
                        cnt = CNT_W'(fill_est);
                    else if (fill_est != 0)
                        cnt = CNT_W'($urandom_range(0, fill_est - 1));
                end
                OP_DROP:
                begin
                    if (pick == 0)
                        cnt = CNT_W'($urandom_range(0, 8191));
                    else if (pick == 1)
                        cnt = CNT_W'(fill_est);
                    else if (pick == 2)
                        cnt = CNT_W'(fill_est + 1);
                    else if (pick == 9)
                        cnt = CNT_W'($urandom_range(0, fill_est));
                    else
                        cnt = CNT_W'($urandom_range(0, (fill_est < 16) ? fill_est : 16));
                end
                OP_RESERVE:
                begin
                    if (pick == 0)
                        cnt = CNT_W'($urandom_range(0, 8191));
                    else if (pick == 1)
                        cnt = CNT_W'(STACK_BYTES - fill_est);
                    else if (pick == 2)
                        cnt = CNT_W'(STACK_BYTES - fill_est + 1);
                    else
                        cnt = CNT_W'($urandom_range(0, 24));
                end
                default:
                    cnt = CNT_W'($urandom_range(0, 8191));
            endcase
            issue_op(op, wc, val, cnt);
        end

        cmd.valid <= 1'b0;
        // the last item is counted by the checker at this edge
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (err_count == 0 && pending == 0)
            $display("byte_stack_multiwidth_tb: done, clean");
        else
            $display("byte_stack_multiwidth_tb: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/bst_pkg.sv
hdl/bst_if.sv
hdl/bst_ram.sv
hdl/bst_ctrl.sv
hdl/bst_align.sv
hdl/byte_stack_multiwidth.sv
hdl/bst_checker.sv
tb/bst_result_checker.sv
tb/byte_stack_multiwidth_tb.sv
